@@ sv/sol_pkg.sv @@
`timescale 1ns / 1ps
// sol_pkg: command, status and cell-operation codes plus fixed field widths
// for the shifting ordered list. Depends on nothing.
package sol_pkg;

    localparam int CMD_W  = 3;
    localparam int IDX_W  = 4;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;
    localparam int SIZE_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_APPEND    = 3'd1,
        CMD_WRITE_AT  = 3'd2,
        CMD_REMOVE_AT = 3'd3,
        CMD_REM_FRONT = 3'd4,
        CMD_REM_BACK  = 3'd5,
        CMD_READ_AT   = 3'd6,
        CMD_CLEAR     = 3'd7
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_LAST  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // What every cell does on an update; the position travels beside it.
    typedef enum logic [2:0] {
        CO_HOLD  = 3'd0,
        CO_LOAD  = 3'd1,
        CO_SHUP  = 3'd2,
        CO_SHDN  = 3'd3,
        CO_CLEAR = 3'd4
    } t_cell_op;

endpackage

@@ sv/sol_cell.sv @@
`timescale 1ns / 1ps
// sol_cell: one entry of the list. Holds a word and, per broadcast operation,
// loads, takes a neighbor's word, clears or holds. Depends on sol_pkg.
module sol_cell
    import sol_pkg::*;
#(
    parameter int POS = 0,
    parameter int PW  = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_op          i_op,
    input  logic [PW-1:0]     i_pos,
    input  logic [WORD_W-1:0] i_value,
    input  logic [WORD_W-1:0] i_prev,
    input  logic [WORD_W-1:0] i_next,
    output logic [WORD_W-1:0] o_word
);

    localparam logic [PW-1:0] MY_POS = PW'(POS);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_op)
            CO_HOLD:  n_word = r_word;
            CO_LOAD: begin
                if (MY_POS == i_pos) n_word = i_value;
            end
            CO_SHUP:  n_word = i_prev;
            // entries above the count are zero, so shifting them is harmless
            CO_SHDN: begin
                if (MY_POS >= i_pos) n_word = i_next;
            end
            CO_CLEAR: n_word = '0;
            default:  n_word = r_word;
        endcase
    end

    // Entries reset to zero: removals pull the word above the count down.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

@@ sv/shifting_ordered_list.sv @@
`timescale 1ns / 1ps
// shifting_ordered_list: top level. Command decode, count and result
// registers, and a chain of sol_cell entries. Depends on sol_pkg, sol_cell.
//
//  channel   handshake            payload
//  command   start / busy         i_command, i_index, i_value
//  result    o_done (one cycle)   o_status, o_count, o_read_value
//  config    i_cfg_we             i_cfg_wdata (initial size)
//
// One command per cycle: every cell loads, shifts from a neighbor, clears
// or holds as the command is taken; the result appears on the next cycle.
// busy stays low; the result strobe lasts one cycle and cannot be stalled.
// Synchronous active-low reset empties the list and zeroes every entry.
module shifting_ordered_list
    import sol_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         i_command,
    input  logic [IDX_W-1:0]         i_index,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic                     i_cfg_we,
    input  logic [SIZE_W-1:0]        i_cfg_wdata,
    output logic                     o_done,
    output logic [STAT_W-1:0]        o_status,
    output logic [CNT_W-1:0]         o_count,
    output logic signed [WORD_W-1:0] o_read_value
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
    localparam int SZW  = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int RD_N = (DEPTH < (1 << IDX_W)) ? DEPTH : (1 << IDX_W);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [SIZE_W-1:0] r_init;
    logic              r_done;
    t_status           r_status;
    t_status           n_status;
    logic [WORD_W-1:0] r_rd;
    logic [WORD_W-1:0] n_rd;
    t_cell_op          cell_op;
    logic [CW-1:0]     cell_pos;
    logic              accept;
    logic              idx_bad;
    logic              full;
    logic              last_one;
    logic [WORD_W-1:0] rd_word;
    t_cmd              cmd;

    logic [WORD_W-1:0] w [DEPTH];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign cmd      = t_cmd'(i_command);
    assign idx_bad  = CMPW'(i_index) >= CMPW'(r_count);
    assign full     = r_count == FULL_CNT;
    assign last_one = r_count <= CW'(1);

    always_comb begin
        rd_word = '0;
        for (int k = 0; k < RD_N; k++) begin
            if (IDX_W'(k) == i_index) rd_word = w[k];
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        n_rd     = '0;
        cell_op  = CO_HOLD;
        cell_pos = '0;
        if (accept) begin
            case (cmd)
                CMD_INS_FRONT: begin
                    if (full) n_status = ST_FULL;
                    else begin
                        cell_op = CO_SHUP;
                        n_count = r_count + CW'(1);
                    end
                end
                CMD_APPEND: begin
                    if (full) n_status = ST_FULL;
                    else begin
                        cell_op  = CO_LOAD;
                        cell_pos = r_count;
                        n_count  = r_count + CW'(1);
                    end
                end
                CMD_WRITE_AT: begin
                    if (idx_bad) n_status = ST_RANGE;
                    else begin
                        cell_op  = CO_LOAD;
                        cell_pos = CW'(i_index);
                    end
                end
                CMD_REMOVE_AT: begin
                    if (last_one) n_status = ST_LAST;
                    else if (idx_bad) n_status = ST_RANGE;
                    else begin
                        cell_op  = CO_SHDN;
                        cell_pos = CW'(i_index);
                        n_count  = r_count - CW'(1);
                    end
                end
                CMD_REM_FRONT: begin
                    if (last_one) n_status = ST_LAST;
                    else begin
                        cell_op  = CO_SHDN;
                        cell_pos = '0;
                        n_count  = r_count - CW'(1);
                    end
                end
                CMD_REM_BACK: begin
                    if (last_one) n_status = ST_LAST;
                    else begin
                        cell_op  = CO_SHDN;
                        cell_pos = r_count - CW'(1);
                        n_count  = r_count - CW'(1);
                    end
                end
                CMD_READ_AT: begin
                    if (idx_bad) n_status = ST_RANGE;
                    else n_rd = rd_word;
                end
                CMD_CLEAR: begin
                    cell_op = CO_CLEAR;
                    // saturate the initial size at the list depth
                    if (SZW'(r_init) > SZW'(DEPTH)) n_count = FULL_CNT;
                    else n_count = CW'(r_init);
                end
                default: begin
                    cell_op = CO_HOLD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_init  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
            if (i_cfg_we) r_init <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_rd     <= n_rd;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] prev_word;
        logic [WORD_W-1:0] next_word;
        if (g == 0) begin : g_first
            assign prev_word = i_value;
        end else begin : g_mid_prev
            assign prev_word = w[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign next_word = '0;
        end else begin : g_mid_next
            assign next_word = w[g+1];
        end
        sol_cell #(
            .POS (g),
            .PW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (cell_op),
            .i_pos   (cell_pos),
            .i_value (i_value),
            .i_prev  (prev_word),
            .i_next  (next_word),
            .o_word  (w[g])
        );
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_count      = CNT_W'(r_count);
    assign o_read_value = r_rd;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("accepted item gave no result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("count above depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_status == ST_FULL) |-> r_count == FULL_CNT)
        else $error("full reported while not full");

    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_status == ST_LAST) |-> r_count <= CW'(1))
        else $error("removal refused with more than one entry");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_status != ST_DONE) |-> r_rd == '0)
        else $error("refused command returned a word");

endmodule

@@ tb/shifting_ordered_list_tb.sv @@
`timescale 1ns / 1ps
// shifting_ordered_list_tb: self-checking bench for the shifting ordered list.
// A directed command table, then random phases with sender gaps, scored against
// typed rows or an in-bench model. Depends on sol_pkg and shifting_ordered_list.
module shifting_ordered_list_tb;
    import sol_pkg::*;

    localparam int LIST_DEPTH      = 16;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 200;

    localparam logic [WORD_W-1:0] W_ZERO = 32'h0000_0000;
    localparam logic [WORD_W-1:0] W_MAX  = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] W_MIN  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] W_ONES = 32'hFFFF_FFFF;

    localparam bit ROW_CMD = 1'b0;
    localparam bit ROW_CFG = 1'b1;
    localparam bit PRED    = 1'b0;
    localparam bit TYPED   = 1'b1;

    typedef struct packed {
        t_status            status;
        logic [CNT_W-1:0]   count;
        logic [WORD_W-1:0]  rd;
    } list_result_t;

    typedef struct packed {
        bit                 is_cfg;
        logic [SIZE_W-1:0]  cfg_value;
        t_cmd               cmd;
        logic [IDX_W-1:0]   idx;
        logic [WORD_W-1:0]  val;
        bit                 typed;
        list_result_t       want;
    } stim_row_t;

    logic                     i_clk;
    logic                     i_rst_n      = 1'b0;
    logic                     start        = 1'b0;
    logic                     busy;
    logic [CMD_W-1:0]         i_command    = '0;
    logic [IDX_W-1:0]         i_index      = '0;
    logic signed [WORD_W-1:0] i_value      = '0;
    logic                     i_cfg_we     = 1'b0;
    logic [SIZE_W-1:0]        i_cfg_wdata  = '0;
    logic                     o_done;
    logic [STAT_W-1:0]        o_status;
    logic [CNT_W-1:0]         o_count;
    logic signed [WORD_W-1:0] o_read_value;

    // In-bench copy of the list and its clear size
    logic [WORD_W-1:0] list_words [LIST_DEPTH] = '{default: '0};
    int                list_len   = 0;
    logic [SIZE_W-1:0] clear_size = '0;

    list_result_t expected_results [$];

    int  error_count     = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  cfg_writes      = 0;
    int  peak_len        = 0;
    int  idle_cycles     = 0;
    int  status_hits [4] = '{default: 0};
    bit  growing         = 1'b1;

    int                phase_idle [PHASES] = '{0, 61, 0, 15, 61, 0, 15, 61};
    logic [SIZE_W-1:0] phase_size [PHASES] = '{5'd0, 5'd4, 5'd16, 5'd31,
                                               5'd1, 5'd20, 5'd9, 5'd15};

    stim_row_t directed_rows [27] = '{
        '{ROW_CMD, 5'd0,  CMD_REM_FRONT, 4'd0,  W_ZERO, TYPED, '{ST_LAST,  5'd0,  W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_REM_BACK,  4'd0,  W_ZERO, TYPED, '{ST_LAST,  5'd0,  W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_REMOVE_AT, 4'd0,  W_ZERO, TYPED, '{ST_LAST,  5'd0,  W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_READ_AT,   4'd0,  W_ZERO, TYPED, '{ST_RANGE, 5'd0,  W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_WRITE_AT,  4'd15, W_ONES, TYPED, '{ST_RANGE, 5'd0,  W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_CLEAR,     4'd0,  W_ZERO, TYPED, '{ST_DONE,  5'd0,  W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_APPEND,    4'd0,  W_MAX,  TYPED, '{ST_DONE,  5'd1,  W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_INS_FRONT, 4'd0,  W_MIN,  TYPED, '{ST_DONE,  5'd2,  W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_READ_AT,   4'd0,  W_ZERO, TYPED, '{ST_DONE,  5'd2,  W_MIN}},
        '{ROW_CMD, 5'd0,  CMD_READ_AT,   4'd1,  W_ZERO, TYPED, '{ST_DONE,  5'd2,  W_MAX}},
        '{ROW_CMD, 5'd0,  CMD_REMOVE_AT, 4'd15, W_ZERO, TYPED, '{ST_RANGE, 5'd2,  W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_WRITE_AT,  4'd1,  W_ONES, PRED,  '0},
        '{ROW_CMD, 5'd0,  CMD_REMOVE_AT, 4'd0,  W_ZERO, PRED,  '0},
        '{ROW_CMD, 5'd0,  CMD_REM_BACK,  4'd0,  W_ZERO, TYPED, '{ST_LAST,  5'd1,  W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_READ_AT,   4'd1,  W_ZERO, TYPED, '{ST_RANGE, 5'd1,  W_ZERO}},
        '{ROW_CFG, 5'd16, CMD_CLEAR,     4'd0,  W_ZERO, PRED,  '0},
        '{ROW_CMD, 5'd0,  CMD_CLEAR,     4'd0,  W_ZERO, TYPED, '{ST_DONE,  5'd16, W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_INS_FRONT, 4'd0,  32'h1234_5678, TYPED,
          '{ST_FULL, 5'd16, W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_APPEND,    4'd0,  W_ONES, TYPED, '{ST_FULL,  5'd16, W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_READ_AT,   4'd15, W_ZERO, TYPED, '{ST_DONE,  5'd16, W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_WRITE_AT,  4'd15, 32'h5A5A_A5A5, PRED, '0},
        '{ROW_CMD, 5'd0,  CMD_READ_AT,   4'd15, W_ZERO, PRED,  '0},
        '{ROW_CMD, 5'd0,  CMD_REM_BACK,  4'd0,  W_ZERO, PRED,  '0},
        '{ROW_CMD, 5'd0,  CMD_REMOVE_AT, 4'd7,  W_ZERO, PRED,  '0},
        '{ROW_CFG, 5'd31, CMD_CLEAR,     4'd0,  W_ZERO, PRED,  '0},
        '{ROW_CMD, 5'd0,  CMD_CLEAR,     4'd0,  W_ZERO, TYPED, '{ST_DONE,  5'd16, W_ZERO}},
        '{ROW_CMD, 5'd0,  CMD_REM_BACK,  4'd0,  W_ZERO, PRED,  '0}
    };

    shifting_ordered_list #(
        .DEPTH(LIST_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_count      (o_count),
        .o_read_value (o_read_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what);
        error_count++;
        $display("MISMATCH result %0d at %0t: %s", results_checked, $time, what);
    endtask

    // Close the gap left by a removal and zero the freed tail entry.
    function automatic void drop_entry(int pos);
        for (int k = pos; k + 1 < list_len; k++) begin
            list_words[k] = list_words[k + 1];
        end
        list_len--;
        list_words[list_len] = '0;
    endfunction

    function automatic list_result_t apply_command(t_cmd cmd, logic [IDX_W-1:0] idx,
                                                   logic [WORD_W-1:0] val);
        list_result_t r;
        r.status = ST_DONE;
        r.rd     = '0;
        case (cmd)
            CMD_INS_FRONT: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int k = list_len; k > 0; k--) begin
                        list_words[k] = list_words[k - 1];
                    end
                    list_words[0] = val;
                    list_len++;
                end
            end
            CMD_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[list_len] = val;
                    list_len++;
                end
            end
            CMD_WRITE_AT: begin
                if (int'(idx) >= list_len) r.status = ST_RANGE;
                else list_words[idx] = val;
            end
            CMD_REMOVE_AT: begin
                if (list_len <= 1) r.status = ST_LAST;
                else if (int'(idx) >= list_len) r.status = ST_RANGE;
                else drop_entry(int'(idx));
            end
            CMD_REM_FRONT: begin
                if (list_len <= 1) r.status = ST_LAST;
                else drop_entry(0);
            end
            CMD_REM_BACK: begin
                if (list_len <= 1) r.status = ST_LAST;
                else drop_entry(list_len - 1);
            end
            CMD_READ_AT: begin
                if (int'(idx) >= list_len) r.status = ST_RANGE;
                else r.rd = list_words[idx];
            end
            default: begin
                foreach (list_words[k]) list_words[k] = '0;
                list_len = (int'(clear_size) > LIST_DEPTH) ? LIST_DEPTH : int'(clear_size);
            end
        endcase
        r.count = list_len[CNT_W-1:0];
        return r;
    endfunction

    // Present one item, hold it until taken, then record what it should return.
    task automatic issue_command(t_cmd cmd, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val,
                                 int idle_pct, bit typed, list_result_t typed_result);
        list_result_t predicted;
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start   <= 1'b0;
            i_value <= $urandom;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_index   <= idx;
        i_value   <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = apply_command(cmd, idx, val);
        items_sent++;
        status_hits[predicted.status]++;
        if (list_len > peak_len) peak_len = list_len;
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_list_idle();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_initial_size(logic [SIZE_W-1:0] size_value);
        wait_list_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size_value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        clear_size = size_value;
        cfg_writes++;
    endtask

    function automatic t_cmd grow_cmd();
        return $urandom_range(0, 1) ? CMD_APPEND : CMD_INS_FRONT;
    endfunction

    function automatic t_cmd shrink_cmd();
        case ($urandom_range(0, 2))
            0:       return CMD_REMOVE_AT;
            1:       return CMD_REM_FRONT;
            default: return CMD_REM_BACK;
        endcase
    endfunction

    // Drift the length up and down in long runs so both full and near-empty get hit.
    task automatic random_command(output t_cmd cmd, output logic [IDX_W-1:0] idx,
                                  output logic [WORD_W-1:0] val);
        int roll;
        if ($urandom_range(0, 39) == 0) growing = !growing;
        roll = $urandom_range(0, 99);
        if (roll < 2)       cmd = CMD_CLEAR;
        else if (roll < 45) cmd = growing ? grow_cmd() : shrink_cmd();
        else if (roll < 58) cmd = growing ? shrink_cmd() : grow_cmd();
        else if (roll < 78) cmd = CMD_READ_AT;
        else if (roll < 92) cmd = CMD_WRITE_AT;
        else                cmd = t_cmd'($urandom_range(0, 7));
        if (list_len > 0 && $urandom_range(0, 99) < 85)
            idx = IDX_W'($urandom_range(0, list_len - 1));
        else
            idx = IDX_W'($urandom_range(0, LIST_DEPTH - 1));
        case ($urandom_range(0, 9))
            0:       val = W_MAX;
            1:       val = W_MIN;
            2:       val = W_ZERO;
            3:       val = W_ONES;
            default: val = $urandom;
        endcase
    endtask

    always @(posedge i_clk) begin : result_check
        list_result_t want;
        if (i_rst_n && o_done === 1'b1) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_count !== want.count)
                    report_mismatch($sformatf("count %0d, want %0d", o_count, want.count));
                if (o_read_value !== want.rd)
                    report_mismatch($sformatf("read value %h, want %h", o_read_value, want.rd));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: %0d cycles without progress", idle_cycles);
            $display("shifting_ordered_list test failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_cmd              cmd;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] val;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].is_cfg) begin
                write_initial_size(directed_rows[n].cfg_value);
            end else begin
                issue_command(directed_rows[n].cmd, directed_rows[n].idx, directed_rows[n].val,
                              0, directed_rows[n].typed, directed_rows[n].want);
            end
        end

        // Each phase starts once outstanding results drain, with a new clear size.
        for (int p = 0; p < PHASES; p++) begin
            write_initial_size(phase_size[p]);
            repeat (ITEMS_PER_PHASE) begin
                random_command(cmd, idx, val);
                issue_command(cmd, idx, val, phase_idle[p], PRED, '0);
            end
        end

        wait_list_idle();
        $display("Covered %0d items (%0d directed) over %0d phases, %0d size writes, peak %0d.",
                 items_sent, items_sent - PHASES * ITEMS_PER_PHASE, PHASES, cfg_writes,
                 peak_len);
        $display("Checked %0d results: done %0d, full %0d, last kept %0d, range %0d.",
                 results_checked, status_hits[ST_DONE], status_hits[ST_FULL],
                 status_hits[ST_LAST], status_hits[ST_RANGE]);
        if (error_count == 0) begin
            $display("shifting_ordered_list test passed");
        end else begin
            $display("shifting_ordered_list test failed");
        end
        $finish;
    end

endmodule
